>>> hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the set-associative LRU tag cache
// Field widths, configuration reset value and the lookup result record.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Byte address and line number width
  localparam int unsigned ADDR_W = 32;
  // Line offset exponent register width and reset value
  localparam int unsigned OFS_W = 5;
  localparam logic [OFS_W-1:0] OFS_RESET = 5'd5;
  // Width of the way field on the result channel
  localparam int unsigned WAY_OUT_W = 2;

  // Outcome of one lookup
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 evicted_valid;
  } res_t;

endpackage

>>> hw/rtl/salc_store.sv
// ----------------------------------------------------------------------------
// salc_store: one-row-per-set storage with registered read
// One write and one read per cycle; a read of the row written in the same
// cycle returns the new data.
// ----------------------------------------------------------------------------
module salc_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ROW_W = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_q;

  // Write the row, read with write-through forwarding
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/salc_index.sv
// ----------------------------------------------------------------------------
// salc_index: line number and set index front end
// Shifts the fetch address down to a line number, then takes it modulo the
// set count by a constant reciprocal multiply and one back-multiply.
// ----------------------------------------------------------------------------
module salc_index #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          take_i,
  input  logic [salc_pkg::ADDR_W-1:0]   addr_i,
  input  logic [salc_pkg::OFS_W-1:0]    offset_i,
  output logic                          valid_o,
  output logic [salc_pkg::ADDR_W-1:0]   line_o,
  output logic [SET_W-1:0]              set_o
);

  import salc_pkg::*;

  // Reciprocal for exact floor division of 32-bit values by NUM_SETS
  localparam int unsigned L_BITS  = $clog2(NUM_SETS);
  localparam int unsigned RECIP_W = 34;
  localparam logic [63:0] RECIP64 = ((64'd1 << (ADDR_W + L_BITS)) / NUM_SETS) + 64'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
  localparam int unsigned PROD_W  = ADDR_W + RECIP_W;
  localparam logic [ADDR_W-1:0] NSETS = ADDR_W'(NUM_SETS);

  logic              v1_q, v2_q, v3_q;
  logic [ADDR_W-1:0] line1_q, line2_q, line3_q;
  logic [ADDR_W-1:0] quo_q;
  logic [SET_W-1:0]  set3_q;

  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] quo_d;
  logic [ADDR_W-1:0] back;
  logic [ADDR_W-1:0] rem;

  // Quotient estimate, exact for every 32-bit line number
  assign prod  = {{RECIP_W{1'b0}}, line1_q} * {{ADDR_W{1'b0}}, RECIP};
  assign quo_d = ADDR_W'(prod >> (ADDR_W + L_BITS));

  // Remainder is the set index
  assign back = quo_q * NSETS;
  assign rem  = line2_q - back;

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      line1_q <= addr_i >> offset_i;
      line2_q <= line1_q;
      quo_q   <= quo_d;
      line3_q <= line2_q;
      set3_q  <= rem[SET_W-1:0];
    end
  end

  assign valid_o = v3_q;
  assign line_o  = line3_q;
  assign set_o   = set3_q;

endmodule

>>> hw/rtl/salc_decide.sv
// ----------------------------------------------------------------------------
// salc_decide: hit detection, way choice and LRU rank update for one set
// Compares all ways, picks the hit, first invalid or least recent way, and
// builds the updated tag, valid and rank rows.
// ----------------------------------------------------------------------------
module salc_decide #(
  parameter int unsigned NUM_WAYS = 4,
  parameter int unsigned WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  logic [salc_pkg::ADDR_W-1:0]                line_i,
  input  logic [NUM_WAYS-1:0][salc_pkg::ADDR_W-1:0]  tag_i,
  input  logic [NUM_WAYS-1:0]                        valid_i,
  input  logic [NUM_WAYS-1:0][WAY_W-1:0]             rank_i,
  output logic [NUM_WAYS-1:0][salc_pkg::ADDR_W-1:0]  tag_o,
  output logic [NUM_WAYS-1:0]                        valid_o,
  output logic [NUM_WAYS-1:0][WAY_W-1:0]             rank_o,
  output salc_pkg::res_t                             res_o
);

  import salc_pkg::*;

  localparam logic [WAY_W-1:0] RANK_LAST = WAY_W'(NUM_WAYS - 1);

  logic             hit;
  logic             any_inv;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] sel;
  logic [WAY_W-1:0] old_rank;
  logic [WAY_W+1:0] sel_x;

  // Find hit, first invalid way and least recently used way
  always_comb begin
    hit     = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (tag_i[w] == line_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rank_i[w] == RANK_LAST) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  // Choose the way to touch
  always_comb begin
    if (hit) begin
      sel = hit_way;
    end else if (any_inv) begin
      sel = inv_way;
    end else begin
      sel = lru_way;
    end
  end

  assign old_rank = rank_i[sel];

  // Build the updated rows: chosen way becomes most recent
  always_comb begin
    tag_o   = tag_i;
    valid_o = valid_i;
    for (int j = 0; j < NUM_WAYS; j++) begin
      if (rank_i[j] < old_rank) begin
        rank_o[j] = rank_i[j] + WAY_W'(1);
      end else begin
        rank_o[j] = rank_i[j];
      end
    end
    rank_o[sel]  = '0;
    tag_o[sel]   = line_i;
    valid_o[sel] = 1'b1;
  end

  // Result record
  assign sel_x              = {2'b00, sel};
  assign res_o.hit           = hit;
  assign res_o.way           = sel_x[WAY_OUT_W-1:0];
  assign res_o.evicted_valid = !hit && !any_inv;

endmodule

>>> hw/rtl/set_assoc_lru_cache_tags_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top: tag and true-LRU replacement of an I-cache
// Looks up one fetch address per transfer and reports hit, way and eviction.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (line offset bits)
//  in      | in        | in_valid_i/in_stall_o   | fetch_address_i
//  out     | out       | out_valid_o/out_stall_i | hit_o, way_o, evicted_valid_o
//
// Throughput is one lookup per cycle unless input is stalled; each lookup is
// registered through line shift, reciprocal multiply, back-multiply, set read
// and compare. After reset a clearing pass writes every set's valid and rank
// row; input is stalled during it, configuration writes are taken.
// Back-to-back lookups to one set see the newest row by read forwarding.
// An output stall on a waiting result holds the pipeline and stalls input.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_top #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [salc_pkg::OFS_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [salc_pkg::ADDR_W-1:0]       fetch_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]    way_o,
  output logic                              evicted_valid_o
);

  import salc_pkg::*;

  localparam int unsigned SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned TAG_ROW = NUM_WAYS * ADDR_W;
  localparam int unsigned ST_ROW  = NUM_WAYS + NUM_WAYS * WAY_W;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

  logic             adv;
  logic             take;
  logic [OFS_W-1:0] offset_q;

  logic              v3;
  logic [ADDR_W-1:0] line3;
  logic [SET_W-1:0]  set3;

  logic              v4_q;
  logic [ADDR_W-1:0] line4_q;
  logic [SET_W-1:0]  set4_q;

  logic              clr_busy_q;
  logic [SET_W-1:0]  clr_idx_q;

  logic [NUM_WAYS-1:0][ADDR_W-1:0] tag_rd, tag_wr;
  logic [NUM_WAYS-1:0]             valid_rd, valid_wr;
  logic [NUM_WAYS-1:0][WAY_W-1:0]  rank_rd, rank_wr, rank_init;
  logic [ST_ROW-1:0]               st_rd, st_wd;
  logic                            st_we;
  logic [SET_W-1:0]                st_wa;
  logic                            upd_we;

  res_t res;
  res_t out_q;
  logic out_valid_q;

  // Pipeline moves whenever the result register can take a value
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv || clr_busy_q;
  assign take       = in_valid_i && !in_stall_o;
  assign upd_we     = v4_q && adv;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFS_RESET;
    end else if (cfg_valid_i) begin
      offset_q <= cfg_data_i;
    end
  end

  // Line number and set index
  salc_index #(
    .NUM_SETS(NUM_SETS),
    .SET_W   (SET_W)
  ) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .take_i  (take),
    .addr_i  (fetch_address_i),
    .offset_i(offset_q),
    .valid_o (v3),
    .line_o  (line3),
    .set_o   (set3)
  );

  // Sweep all sets after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + SET_W'(1);
      if (clr_idx_q == LAST_SET) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Reset rank row: rank equals way index
  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      rank_init[j] = WAY_W'(j);
    end
  end

  // Tag rows
  salc_store #(
    .DEPTH(NUM_SETS),
    .ROW_W(TAG_ROW),
    .AW   (SET_W)
  ) u_tag_store (
    .clk_i    (clk_i),
    .rd_en_i  (adv),
    .rd_addr_i(set3),
    .rd_data_o(tag_rd),
    .wr_en_i  (upd_we),
    .wr_addr_i(set4_q),
    .wr_data_i(tag_wr)
  );

  // Valid and rank rows, written by the clearing pass or by a lookup
  assign st_we = clr_busy_q || upd_we;
  assign st_wa = clr_busy_q ? clr_idx_q : set4_q;
  assign st_wd = clr_busy_q ? {{NUM_WAYS{1'b0}}, rank_init} : {valid_wr, rank_wr};

  salc_store #(
    .DEPTH(NUM_SETS),
    .ROW_W(ST_ROW),
    .AW   (SET_W)
  ) u_state_store (
    .clk_i    (clk_i),
    .rd_en_i  (adv),
    .rd_addr_i(set3),
    .rd_data_o(st_rd),
    .wr_en_i  (st_we),
    .wr_addr_i(st_wa),
    .wr_data_i(st_wd)
  );

  assign {valid_rd, rank_rd} = st_rd;

  // Lookup stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      line4_q <= line3;
      set4_q  <= set3;
    end
  end

  // Compare and update
  salc_decide #(
    .NUM_WAYS(NUM_WAYS),
    .WAY_W   (WAY_W)
  ) u_decide (
    .line_i (line4_q),
    .tag_i  (tag_rd),
    .valid_i(valid_rd),
    .rank_i (rank_rd),
    .tag_o  (tag_wr),
    .valid_o(valid_wr),
    .rank_o (rank_wr),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign way_o           = out_q.way;
  assign evicted_valid_o = out_q.evicted_valid;

  // No lookup is in flight while the clearing pass runs
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!v4_q && !v3 && !out_valid_q))
    else $error("lookup in flight during clearing pass");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported together with eviction");

  // A held lookup keeps its line and set
  a_hold_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !adv) |=> (v4_q && $stable(line4_q) && $stable(set4_q)))
    else $error("stalled lookup changed");

  // The set row is written only by the clearing pass or an advancing lookup
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (clr_busy_q || v4_q))
    else $error("set row written without a source");

endmodule
